/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies; define SYNTH to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/tods_pkg.sv */
// constants, types and helpers for the time of day parser
// no dependencies
package tods_pkg;

    localparam int FRACTION_DIGITS = 9;
    localparam logic [3:0] FRAC_DIGITS_MAX = 4'(FRACTION_DIGITS);

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
    localparam logic [18:0] SEC_PER_MIN  = 19'd60;
    localparam logic [18:0] SEC_PER_HOUR = 19'd3600;
    localparam logic [48:0] NS_MAX       = 49'd362439999999999;

    typedef struct packed {
        logic        err;
        logic [6:0]  hour_value;
        logic [6:0]  minute_value;
        logic [6:0]  second_value;
        logic [29:0] fraction_value;
        logic [3:0]  fraction_digits;
    } fields_t;

    function automatic logic [29:0] pow10(input logic [3:0] e);
        logic [29:0] p;
        case (e)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd0;
        endcase
        return p;
    endfunction

endpackage

/* hw/rtl/tods_char_parser.sv */
// per-character field tracking for the time of day parser
// depends on tods_pkg
module tods_char_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            char_code,
    input  logic                  last_char,
    output tods_pkg::fields_t     fields
);

    typedef enum logic [2:0] {
        FLD_HOUR,
        FLD_MIN,
        FLD_SEC,
        FLD_FRAC,
        FLD_DONE
    } field_t;

    field_t            field_reg, field_next;
    tods_pkg::fields_t acc_reg, acc_next;
    logic [1:0]        fdig_reg, fdig_next;

    logic       digit;
    logic [3:0] d;
    logic [7:0] delim;
    field_t     field_inc;

    assign digit = (char_code >= tods_pkg::CHAR_ZERO) && (char_code <= tods_pkg::CHAR_NINE);
    assign d     = 4'(char_code - tods_pkg::CHAR_ZERO);

    always_comb
    begin
        case (field_reg)
            FLD_HOUR: begin delim = tods_pkg::CHAR_COLON; field_inc = FLD_MIN;  end
            FLD_MIN:  begin delim = tods_pkg::CHAR_COLON; field_inc = FLD_SEC;  end
            FLD_SEC:  begin delim = tods_pkg::CHAR_DOT;   field_inc = FLD_FRAC; end
            default:  begin delim = tods_pkg::CHAR_SPACE; field_inc = FLD_DONE; end
        endcase
    end

    always_comb
    begin
        field_next = field_reg;
        acc_next   = acc_reg;
        fdig_next  = fdig_reg;
        if (acc_reg.err)
        begin
            acc_next = acc_reg;
        end
        else if (field_reg == FLD_DONE)
        begin
            acc_next.err = 1'b1;
        end
        else if (char_code == delim)
        begin
            field_next = field_inc;
            fdig_next  = 2'd0;
        end
        else if (!digit)
        begin
            acc_next.err = 1'b1;
        end
        else if (field_reg == FLD_FRAC)
        begin
            if (acc_reg.fraction_digits >= tods_pkg::FRAC_DIGITS_MAX)
            begin
                acc_next.err = 1'b1;
            end
            else
            begin
                acc_next.fraction_value  = 30'(acc_reg.fraction_value * 30'd10 + 30'(d));
                acc_next.fraction_digits = 4'(acc_reg.fraction_digits + 4'd1);
            end
        end
        else if (fdig_reg >= 2'd2)
        begin
            acc_next.err = 1'b1;
        end
        else
        begin
            fdig_next = 2'(fdig_reg + 2'd1);
            case (field_reg)
                FLD_HOUR: acc_next.hour_value   = 7'(acc_reg.hour_value * 7'd10 + 7'(d));
                FLD_MIN:  acc_next.minute_value = 7'(acc_reg.minute_value * 7'd10 + 7'(d));
                default:  acc_next.second_value = 7'(acc_reg.second_value * 7'd10 + 7'(d));
            endcase
        end
    end

    assign fields = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg <= FLD_HOUR;
            acc_reg   <= '0;
            fdig_reg  <= 2'd0;
        end
        else if (take)
        begin
            if (last_char)
            begin
                field_reg <= FLD_HOUR;
                acc_reg   <= '0;
                fdig_reg  <= 2'd0;
            end
            else
            begin
                field_reg <= field_next;
                acc_reg   <= acc_next;
                fdig_reg  <= fdig_next;
            end
        end
    end

endmodule

/* hw/rtl/time_of_day_string_parser_core.sv */
// Time of day parser: takes one ASCII character per cycle while in_ready is high (H:M:S.fraction
// with an optional trailing space) and, on the character marked last, returns nanoseconds since
// midnight and an error flag. The fields of the last character are registered in s1, the fraction
// scaling multiply and the seconds sum in s2, the seconds to nanoseconds multiply in s3, and the
// sum in the output register that drives out_valid. Stages hold their word while the output
// waits, so input keeps flowing until every stage is full.
// Depends on tods_pkg, tods_char_parser and assert_macros.svh.
`include "assert_macros.svh"

module time_of_day_string_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [48:0] nanoseconds,
    output logic        parse_error
);

    tods_pkg::fields_t fields;
    logic              accept;
    logic              free1, free2, free3, free_out;

    logic              s1_valid_reg;
    tods_pkg::fields_t s1_fields_reg;
    logic              s2_valid_reg, s2_err_reg;
    logic [29:0]       s2_frac_ns_reg;
    logic [18:0]       s2_sec_reg;
    logic              s3_valid_reg, s3_err_reg;
    logic [29:0]       s3_frac_ns_reg;
    logic [48:0]       s3_sec_ns_reg;
    logic              out_valid_reg, parse_error_reg;
    logic [48:0]       nanoseconds_reg;

    logic [59:0]       frac_prod;
    logic [18:0]       sec_total;
    logic [48:0]       sec_ns;
    logic [3:0]        scale_exp;

    assign free_out = !out_valid_reg || out_ready;
    assign free3    = !s3_valid_reg || free_out;
    assign free2    = !s2_valid_reg || free3;
    assign free1    = !s1_valid_reg || free2;
    assign in_ready = free1;
    assign accept   = in_valid && free1;

    tods_char_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (accept),
        .char_code (char_code),
        .last_char (last_char),
        .fields    (fields)
    );

    // fraction scaled to nine digits, plus whole seconds
    assign scale_exp = 4'(4'd9 - s1_fields_reg.fraction_digits);
    assign frac_prod = s1_fields_reg.fraction_value * tods_pkg::pow10(scale_exp);
    assign sec_total = 19'(s1_fields_reg.second_value)
                     + 19'(19'(s1_fields_reg.minute_value) * tods_pkg::SEC_PER_MIN)
                     + 19'(19'(s1_fields_reg.hour_value) * tods_pkg::SEC_PER_HOUR);
    assign sec_ns    = 49'(s2_sec_reg) * 49'(tods_pkg::NS_PER_SEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                s1_valid_reg <= accept && last_char;
            end
            if (free2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (free3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (free_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            s1_fields_reg <= fields;
        end
        if (free2)
        begin
            s2_err_reg     <= s1_fields_reg.err;
            s2_frac_ns_reg <= frac_prod[29:0];
            s2_sec_reg     <= sec_total;
        end
        if (free3)
        begin
            s3_err_reg     <= s2_err_reg;
            s3_frac_ns_reg <= s2_frac_ns_reg;
            s3_sec_ns_reg  <= sec_ns;
        end
        if (free_out)
        begin
            parse_error_reg <= s3_err_reg;
            nanoseconds_reg <= s3_err_reg ? 49'd0 : 49'(s3_sec_ns_reg + 49'(s3_frac_ns_reg));
        end
    end

    assign out_valid   = out_valid_reg;
    assign nanoseconds = nanoseconds_reg;
    assign parse_error = parse_error_reg;

    `ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid_reg && parse_error_reg, nanoseconds_reg == 49'd0)
    `ASSERT_IMPLY(a_ns_range, clk, rst_n, out_valid_reg, nanoseconds_reg <= tods_pkg::NS_MAX)
    `ASSERT_NEXT(a_last_loads, clk, rst_n, accept && last_char, s1_valid_reg)

endmodule
